// ===== design/param_crc16_frame_engine_core_defines.svh =====
// Assertion macros shared by the CRC frame engine RTL.
`ifndef PARAM_CRC16_FRAME_ENGINE_CORE_DEFINES_SVH
`define PARAM_CRC16_FRAME_ENGINE_CORE_DEFINES_SVH

// Condition in the same cycle implies the consequence in that cycle.
`define PCFE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcfe assertion failed");

// Condition in one cycle implies the consequence in the next cycle.
`define PCFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcfe assertion failed");

`endif

// ===== design/pcfe_pkg.sv =====
// Types, constants and register codes of the CRC frame engine.
`default_nettype none

package pcfe_pkg;

	localparam int CRC_WIDTH = 16;

	typedef logic [CRC_WIDTH-1:0] crc_t;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_POLY        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_VALUE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_IN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REFLECT_OUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_XOR_OUT     = 3'd4;

	localparam logic [15:0] POLY_RESET        = 16'h1021;
	localparam logic [15:0] INIT_RESET        = 16'hFFFF;
	localparam logic        REFLECT_IN_RESET  = 1'b1;
	localparam logic        REFLECT_OUT_RESET = 1'b1;
	localparam logic [15:0] XOR_OUT_RESET     = 16'hFFFF;

	localparam logic REQ_PAYLOAD = 1'b0;
	localparam logic REQ_CHECK   = 1'b1;

	localparam logic [1:0] PAYLOAD_SAT = 2'd2;

	typedef struct packed {
		logic [15:0] poly;
		logic [15:0] init_value;
		logic        reflect_in;
		logic        reflect_out;
		logic [15:0] xor_out;
	} cfg_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
		logic       frame_start;
	} req_t;

	typedef struct packed {
		logic [15:0] crc_value;
		logic        check_done;
		logic        check_ok;
	} rsp_t;

	typedef struct packed {
		crc_t       crc_register;
		logic [1:0] payload_count;
		logic       check_index;
		logic       check_mismatch;
	} state_t;

endpackage

`default_nettype wire

// ===== design/pcfe_cfg.sv =====
// Configuration register file of the CRC frame engine.
`default_nettype none

module pcfe_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [pcfe_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0]                    wr_data,
	output pcfe_pkg::cfg_t                      cfg
);

	pcfe_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly        <= pcfe_pkg::POLY_RESET;
			cfg_q.init_value  <= pcfe_pkg::INIT_RESET;
			cfg_q.reflect_in  <= pcfe_pkg::REFLECT_IN_RESET;
			cfg_q.reflect_out <= pcfe_pkg::REFLECT_OUT_RESET;
			cfg_q.xor_out     <= pcfe_pkg::XOR_OUT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				pcfe_pkg::CFG_POLY:        cfg_q.poly        <= wr_data;
				pcfe_pkg::CFG_INIT_VALUE:  cfg_q.init_value  <= wr_data;
				pcfe_pkg::CFG_REFLECT_IN:  cfg_q.reflect_in  <= wr_data[0];
				pcfe_pkg::CFG_REFLECT_OUT: cfg_q.reflect_out <= wr_data[0];
				pcfe_pkg::CFG_XOR_OUT:     cfg_q.xor_out     <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/pcfe_fold.sv =====
// Combinational next-state and result logic for one item of the CRC engine.
`default_nettype none

module pcfe_fold (
	input  wire pcfe_pkg::cfg_t   cfg,
	input  wire pcfe_pkg::state_t state,
	input  wire pcfe_pkg::req_t   item,
	output pcfe_pkg::state_t      state_next,
	output pcfe_pkg::rsp_t        rsp
);

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic pcfe_pkg::crc_t finished(input pcfe_pkg::crc_t r,
			input logic refl, input logic [15:0] xo);
		pcfe_pkg::crc_t v;
		for (int i = 0; i < pcfe_pkg::CRC_WIDTH; i++) begin
			v[i] = refl ? r[pcfe_pkg::CRC_WIDTH-1-i] : r[i];
		end
		return v ^ pcfe_pkg::crc_t'(xo);
	endfunction

	pcfe_pkg::state_t s;
	pcfe_pkg::crc_t   poly_m;
	pcfe_pkg::crc_t   r;
	logic [7:0]       b;
	logic [31:0]      fin_ext;
	logic [7:0]       expect_byte;
	logic             done;
	logic             ok;

	always_comb begin
		s = state;
		done = 1'b0;
		ok = 1'b0;
		poly_m = pcfe_pkg::crc_t'(cfg.poly);
		if (item.frame_start) begin
			s.crc_register   = pcfe_pkg::crc_t'(cfg.init_value);
			s.payload_count  = '0;
			s.check_index    = 1'b0;
			s.check_mismatch = 1'b0;
		end
		b = cfg.reflect_in ? rev8(item.data_byte) : item.data_byte;
		// Byte goes into the top of the register, then eight shift steps.
		r = s.crc_register ^ (pcfe_pkg::crc_t'(b) << (pcfe_pkg::CRC_WIDTH - 8));
		for (int i = 0; i < 8; i++) begin
			if (r[pcfe_pkg::CRC_WIDTH-1]) begin
				r = (r << 1) ^ poly_m;
			end else begin
				r = r << 1;
			end
		end
		fin_ext = 32'(finished(s.crc_register, cfg.reflect_out, cfg.xor_out));
		expect_byte = s.check_index ? fin_ext[15:8] : fin_ext[7:0];
		if (item.req_type == pcfe_pkg::REQ_PAYLOAD) begin
			s.crc_register = r;
			if (s.payload_count != pcfe_pkg::PAYLOAD_SAT) begin
				s.payload_count = s.payload_count + 2'd1;
			end
			s.check_index    = 1'b0;
			s.check_mismatch = 1'b0;
		end else begin
			if (item.data_byte != expect_byte) begin
				s.check_mismatch = 1'b1;
			end
			if (!s.check_index) begin
				s.check_index = 1'b1;
			end else begin
				done = 1'b1;
				ok = !s.check_mismatch && (s.payload_count == pcfe_pkg::PAYLOAD_SAT);
				s.check_index    = 1'b0;
				s.check_mismatch = 1'b0;
			end
		end
		state_next = s;
	end

	logic [31:0] fin_out;

	assign fin_out = 32'(finished(state_next.crc_register, cfg.reflect_out, cfg.xor_out));
	assign rsp.crc_value  = fin_out[15:0];
	assign rsp.check_done = done;
	assign rsp.check_ok   = ok;

endmodule

`default_nettype wire

// ===== design/param_crc16_frame_engine_core.sv =====
// Top level of the configurable CRC frame engine.
// The engine takes one item per clock cycle and returns one result per item: the item is
// captured in an input register, the full byte fold (eight polynomial steps as one XOR
// network), the check-byte compare and the finished-CRC reflect and XOR are computed in
// one pass, and the result lands in an output register. Throughput is set by that
// single-pass fold between the two registers; a stalled output holds the pipeline. The user
// must write configuration through the plain write port only while idle; it is unchecked.
`default_nettype none

module param_crc16_frame_engine_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire pcfe_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output pcfe_pkg::rsp_t                      rsp,
	input  wire logic                           wr_en,
	input  wire logic [pcfe_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [15:0]                    wr_data
);

`include "param_crc16_frame_engine_core_defines.svh"

	pcfe_pkg::cfg_t   cfg;
	pcfe_pkg::state_t state_q;
	pcfe_pkg::state_t state_next;
	pcfe_pkg::req_t   item_s1;
	logic             valid_s1;
	pcfe_pkg::rsp_t   rsp_comb;
	pcfe_pkg::rsp_t   rsp_s2;
	logic             rsp_valid_s2;
	logic             advance;
	logic             accept;

	pcfe_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pcfe_fold u_fold (
		.cfg        (cfg),
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.rsp        (rsp_comb)
	);

	// The held item moves on whenever the output register is free or being emptied.
	assign advance   = !rsp_valid_s2 || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_s2 <= 1'b0;
			state_q.crc_register   <= pcfe_pkg::crc_t'(pcfe_pkg::INIT_RESET);
			state_q.payload_count  <= '0;
			state_q.check_index    <= 1'b0;
			state_q.check_mismatch <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
		end
		if (advance && valid_s1) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	`PCFE_ASSERT_NEXT(a_item_reaches_output, valid_s1 && advance, rsp_valid_s2)
	`PCFE_ASSERT_IMPL(a_ok_needs_done, rsp_valid_s2 && rsp_s2.check_ok, rsp_s2.check_done)
	`PCFE_ASSERT_IMPL(a_mismatch_only_mid_pair, !state_q.check_index, !state_q.check_mismatch)
	`PCFE_ASSERT_IMPL(a_count_saturates, 1'b1, state_q.payload_count != 2'd3)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the configurable CRC frame engine.
`timescale 1ns / 1ps

module tb;
	import pcfe_pkg::*;

	localparam int NUM_PHASES      = 9;
	localparam int ITEMS_PER_PHASE = 72;
	localparam int NUM_ROWS        = 25;
	localparam bit [NUM_PHASES-1:0] RAND_PHASES = 9'b100100000;

	typedef enum logic [1:0] {SRC_FIXED, SRC_GOOD, SRC_BAD} byte_src_e;

	typedef struct {
		logic       req_type;
		byte_src_e  src;
		logic [7:0] data;
		logic       fs;
		bit         typed;
		rsp_t       want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [15:0]          wr_data;

	// Predictor state and its copy of the configuration.
	crc_t        crc_reg;
	logic [1:0]  pay_cnt;
	logic        chk_idx;
	logic        chk_bad;
	logic [15:0] cfg_poly;
	logic [15:0] cfg_init;
	logic        cfg_rin;
	logic        cfg_rout;
	logic [15:0] cfg_xor;

	rsp_t crc_expected [$];
	rsp_t want_rsp;
	int   fails;
	int   items_sent;
	int   send_idle_pct;
	int   rcv_stall_pct;

	// Row with the X-25 check string "123456789" ends on the well-known value 0x906E.
	dir_row_t dir_rows [NUM_ROWS] = '{
		'{REQ_CHECK,   SRC_FIXED, 8'h00, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_FIXED, 8'h00, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{REQ_CHECK,   SRC_FIXED, 8'hFF, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_FIXED, 8'hFF, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h31, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h32, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h33, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h34, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h35, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h36, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h37, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h38, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h39, 1'b0, 1'b1, '{16'h906E, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b1, '{16'h906E, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b1, '{16'h906E, 1'b1, 1'b1}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_BAD,   8'h00, 1'b0, 1'b1, '{16'h906E, 1'b1, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_PAYLOAD, SRC_FIXED, 8'hFF, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b0, 1'b0, '{16'h0000, 1'b0, 1'b0}},
		'{REQ_CHECK,   SRC_GOOD,  8'h00, 1'b1, 1'b0, '{16'h0000, 1'b0, 1'b0}}
	};

	// Settings walked by the random part; the flagged phases draw fresh random values.
	cfg_t phase_cfg [NUM_PHASES] = '{
		'{16'h1021, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF},
		'{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF},
		'{16'h8005, 16'h0000, 1'b1, 1'b1, 16'h0000},
		'{16'h1021, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
		'{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
		'{16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'hFFFF},
		'{16'h3D65, 16'h0000, 1'b0, 1'b1, 16'hFFFF},
		'{16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000}
	};

	param_crc16_frame_engine_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic crc_t reverse_crc(crc_t v);
		crc_t r;
		for (int i = 0; i < CRC_WIDTH; i++)
			r[i] = v[CRC_WIDTH-1-i];
		return r;
	endfunction

	function automatic logic [7:0] reverse_byte(logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++)
			r[i] = v[7-i];
		return r;
	endfunction

	function automatic crc_t finished_crc();
		crc_t r;
		r = cfg_rout ? reverse_crc(crc_reg) : crc_reg;
		return r ^ crc_t'(cfg_xor);
	endfunction

	function automatic void fold_byte(logic [7:0] b);
		logic [7:0] v;
		v = cfg_rin ? reverse_byte(b) : b;
		crc_reg = crc_reg ^ (crc_t'(v) << (CRC_WIDTH - 8));
		for (int i = 0; i < 8; i++) begin
			if (crc_reg[CRC_WIDTH-1])
				crc_reg = (crc_reg << 1) ^ crc_t'(cfg_poly);
			else
				crc_reg = crc_reg << 1;
		end
	endfunction

	// The check byte that the next check item must carry to match.
	function automatic logic [7:0] check_byte();
		logic [31:0] f;
		f = 32'(finished_crc());
		return chk_idx ? f[15:8] : f[7:0];
	endfunction

	function automatic rsp_t predict_rsp(req_t it);
		rsp_t        r;
		logic [31:0] f;
		r = '0;
		if (it.frame_start) begin
			crc_reg = crc_t'(cfg_init);
			pay_cnt = '0;
			chk_idx = 1'b0;
			chk_bad = 1'b0;
		end
		if (it.req_type == REQ_PAYLOAD) begin
			fold_byte(it.data_byte);
			if (pay_cnt < PAYLOAD_SAT)
				pay_cnt = pay_cnt + 2'd1;
			chk_idx = 1'b0;
			chk_bad = 1'b0;
		end else begin
			if (it.data_byte != check_byte())
				chk_bad = 1'b1;
			if (!chk_idx) begin
				chk_idx = 1'b1;
			end else begin
				r.check_done = 1'b1;
				r.check_ok   = !chk_bad && pay_cnt >= PAYLOAD_SAT;
				chk_idx = 1'b0;
				chk_bad = 1'b0;
			end
		end
		f = 32'(finished_crc());
		r.crc_value = f[15:0];
		return r;
	endfunction

	function automatic req_t make_item(logic rt, byte_src_e src, logic [7:0] d, logic fs);
		req_t it;
		it.req_type    = rt;
		it.frame_start = fs;
		case (src)
			SRC_GOOD: it.data_byte = check_byte();
			SRC_BAD:  it.data_byte = check_byte() ^ 8'($urandom_range(1, 255));
			default:  it.data_byte = d;
		endcase
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input req_t it, input bit typed, input rsp_t want);
		rsp_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pred = predict_rsp(it);
		crc_expected.push_back(typed ? want : pred);
		items_sent++;
		@(negedge clk);
	endtask

	// Drains the block so that nothing is in flight.
	task automatic settle();
		req_valid <= 1'b0;
		while (crc_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes all five registers, then the unused indexes, which must be ignored.
	task automatic program_cfg(input cfg_t c);
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          val;
		for (int i = 0; i < 8; i++) begin
			idx = i[CFG_IDX_W-1:0];
			case (idx)
				CFG_POLY: begin
					val = c.poly;
					cfg_poly = val;
				end
				CFG_INIT_VALUE: begin
					val = c.init_value;
					cfg_init = val;
				end
				CFG_REFLECT_IN: begin
					val = (16'($urandom) & 16'hFFFE) | 16'(c.reflect_in);
					cfg_rin = val[0];
				end
				CFG_REFLECT_OUT: begin
					val = (16'($urandom) & 16'hFFFE) | 16'(c.reflect_out);
					cfg_rout = val[0];
				end
				CFG_XOR_OUT: begin
					val = c.xor_out;
					cfg_xor = val;
				end
				default: val = 16'($urandom);
			endcase
			wr_en    <= 1'b1;
			wr_index <= idx;
			wr_data  <= val;
			@(negedge clk);
		end
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (crc_expected.size() == 0) begin
				$error("unexpected result: crc_value %h", rsp.crc_value);
				fails++;
			end else begin
				want_rsp = crc_expected.pop_front();
				if (rsp.crc_value !== want_rsp.crc_value) begin
					$error("crc_value: expected %h, got %h", want_rsp.crc_value, rsp.crc_value);
					fails++;
				end
				if (rsp.check_done !== want_rsp.check_done) begin
					$error("check_done: expected %b, got %b",
						want_rsp.check_done, rsp.check_done);
					fails++;
				end
				if (rsp.check_ok !== want_rsp.check_ok) begin
					$error("check_ok: expected %b, got %b", want_rsp.check_ok, rsp.check_ok);
					fails++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("param_crc16_frame_engine_core regression: fail");
		$finish;
	end

	initial begin
		cfg_t c;
		req_t it;
		int   start_cnt;
		int   len;
		int   nchk;
		int   bad_at;
		bit   with_start;
		bit   paused;
		int   pick;

		fails         = 0;
		items_sent    = 0;
		send_idle_pct = 26;
		rcv_stall_pct = 79;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		wr_en     = 1'b0;
		wr_index  = '0;
		wr_data   = '0;
		cfg_poly  = POLY_RESET;
		cfg_init  = INIT_RESET;
		cfg_rin   = REFLECT_IN_RESET;
		cfg_rout  = REFLECT_OUT_RESET;
		cfg_xor   = XOR_OUT_RESET;
		crc_reg   = crc_t'(INIT_RESET);
		pay_cnt   = '0;
		chk_idx   = 1'b0;
		chk_bad   = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			it = make_item(dir_rows[r].req_type, dir_rows[r].src, dir_rows[r].data,
				dir_rows[r].fs);
			send_item(it, dir_rows[r].typed, dir_rows[r].want);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			c = phase_cfg[ph];
			if (RAND_PHASES[ph]) begin
				c.poly        = 16'($urandom);
				c.init_value  = 16'($urandom);
				c.reflect_in  = 1'($urandom_range(1));
				c.reflect_out = 1'($urandom_range(1));
				c.xor_out     = 16'($urandom);
			end
			program_cfg(c);
			if (ph < 3) begin
				send_idle_pct = 26;
				rcv_stall_pct = 79;
			end else if (ph < 6) begin
				send_idle_pct = 79;
				rcv_stall_pct = 26;
			end else begin
				send_idle_pct = 0;
				rcv_stall_pct = 0;
			end
			start_cnt = items_sent;
			paused    = 1'b0;
			while (items_sent - start_cnt < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 8) begin
					it.req_type    = 1'($urandom_range(1));
					it.data_byte   = 8'($urandom);
					it.frame_start = ($urandom_range(4) == 0);
					send_item(it, 1'b0, '0);
				end else begin
					// A frame: payload, then its check bytes (usually a pair), now and then broken.
					len = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
					with_start = ($urandom_range(9) != 0);
					for (int k = 0; k < len; k++)
						send_item(make_item(REQ_PAYLOAD, SRC_FIXED, 8'($urandom),
							with_start && k == 0), 1'b0, '0);
					pick = $urandom_range(9);
					nchk = (pick == 0) ? 1 : (pick < 8) ? 2 : 4;
					bad_at = ($urandom_range(6) == 0) ? int'($urandom_range(nchk - 1)) : -1;
					for (int k = 0; k < nchk; k++)
						send_item(make_item(REQ_CHECK, (k == bad_at) ? SRC_BAD : SRC_GOOD,
							8'h00, with_start && len == 0 && k == 0), 1'b0, '0);
				end
				if (ph == 4 && !paused && items_sent - start_cnt >= ITEMS_PER_PHASE / 2) begin
					settle();
					paused = 1'b1;
				end
			end
		end

		req_valid     <= 1'b0;
		rcv_stall_pct = 0;
		while (crc_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("param_crc16_frame_engine_core regression: pass");
		else
			$display("param_crc16_frame_engine_core regression: fail");
		$finish;
	end

endmodule
